// ===== hdl/rds_pkg.sv =====
// ----------------------------------------------------------------------------
// rds_pkg
// Types, register indexes and constants for the relocation diff scanner.
// ----------------------------------------------------------------------------
package rds_pkg;

    localparam int MAX_RELOCS   = 16384;
    localparam int LEN_MAX      = 1048576;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PSP_SEGMENT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_CODE_SEGMENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_POINTER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_SEGMENT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_POINTER      = 3'd4;

    localparam logic [1:0] KIND_RELOC        = 2'd0;
    localparam logic [1:0] KIND_HEADER       = 2'd1;
    localparam logic [1:0] KIND_HEADER_OVFL  = 2'd2;

    localparam logic [15:0] PARA_BYTES       = 16'h0010;
    localparam logic [16:0] HDR_FIXED_ROUND  = 17'd539;
    localparam logic [15:0] SP_ADJUST        = 16'd2;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic       is_last;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] reloc_segment;
        logic [11:0] reloc_offset_low;
        logic [20:0] image_length;
        logic [14:0] reloc_total;
        logic [15:0] header_paragraphs;
        logic [15:0] page_total;
        logic [8:0]  last_page_bytes;
        logic [15:0] rel_stack_segment;
        logic [15:0] rel_code_segment;
        logic [15:0] start_stack_pointer;
        logic [15:0] start_ip;
    } t_result;

    function automatic logic [20:0] sat_grow(input logic [20:0] len, input logic [1:0] by);
        logic [21:0] sum;
        sum = {1'b0, len} + {20'd0, by};
        if (sum > 22'(LEN_MAX)) begin
            return 21'(LEN_MAX);
        end
        return sum[20:0];
    endfunction

endpackage

// ===== hdl/relocation_diff_scanner_core.sv =====
// ----------------------------------------------------------------------------
// relocation_diff_scanner_core
// Byte-pair diff scanner that finds relocation entries and sums up the header.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one byte pair of the two dumps per
// transaction; is_last marks the final pair and makes the block emit the
// header summary after any relocation entry of that same pair.
// Output channel: o_valid / i_stall carry result transactions in order.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and 16-bit
// data; the port is always ready.
// Output: a result enters the four-entry result queue when its pair is taken.
// Throughput: one byte pair per cycle while o_stall is low. A pair yields at
// most two results and the output moves one per cycle while i_stall is low,
// so the queue sets the rate: o_stall rises while under two slots are free.
// Stall: while i_stall is high the head result holds and the queue fills;
// once it cannot take two more results, o_stall rises.
// Reset (synchronous, active low): clears scan state, configuration
// registers and the result queue; the block takes pairs in the next cycle.
// ----------------------------------------------------------------------------
module relocation_diff_scanner_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  rds_pkg::t_item                i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output rds_pkg::t_result              o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rds_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rds_pkg::*;

    logic [15:0] r_psp_segment, r_entry_code_segment, r_entry_pointer;
    logic [15:0] r_stack_segment, r_stack_pointer;

    logic        r_pending, n_pending;
    logic [7:0]  r_held_first, n_held_first;
    logic [7:0]  r_held_second, n_held_second;
    logic [20:0] r_length, n_length;
    logic [14:0] r_entries, n_entries;
    logic        r_stopped, n_stopped;
    logic        r_overflow, n_overflow;

    t_result              r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_rd_ptr, r_wr_ptr;
    logic [QUEUE_CW-1:0]  r_count;

    logic        in_take, out_take, reloc_hit;
    logic [15:0] w1, w2;
    logic [16:0] hdr_sum;
    logic [16:0] hbytes;
    logic [20:0] flen;
    logic [11:0] pages;
    logic [15:0] base_seg;
    t_result     reloc_res, hdr_res, push0;
    logic [1:0]  push_n;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_count > QUEUE_CW'(QUEUE_DEPTH - 2);
    assign o_valid     = r_count != '0;
    assign o_result    = r_queue[r_rd_ptr];
    assign in_take     = i_valid && !o_stall;
    assign out_take    = o_valid && !i_stall;

    assign w1 = {i_item.byte_first, r_held_first};
    assign w2 = {i_item.byte_second, r_held_second};

    always_comb begin
        n_pending     = r_pending;
        n_held_first  = r_held_first;
        n_held_second = r_held_second;
        n_length      = r_length;
        n_entries     = r_entries;
        n_stopped     = r_stopped;
        n_overflow    = r_overflow;
        reloc_hit     = 1'b0;
        if (!r_stopped) begin
            if (r_pending) begin
                n_pending = 1'b0;
                if (w2 == w1 + 16'd1) begin
                    if (r_entries >= 15'(MAX_RELOCS)) begin
                        n_overflow = 1'b1;
                        n_stopped  = 1'b1;
                    end else begin
                        reloc_hit = 1'b1;
                        n_entries = r_entries + 15'd1;
                        n_length  = sat_grow(r_length, 2'd2);
                    end
                end else begin
                    n_stopped = 1'b1;
                end
            end else if (i_item.byte_first == i_item.byte_second) begin
                n_length = sat_grow(r_length, 2'd1);
            end else if (i_item.is_last) begin
                n_stopped = 1'b1;
            end else begin
                n_pending     = 1'b1;
                n_held_first  = i_item.byte_first;
                n_held_second = i_item.byte_second;
            end
        end
    end

    always_comb begin
        hdr_sum   = {n_entries, 2'b00} + HDR_FIXED_ROUND;
        hbytes    = {hdr_sum[16:9], 9'd0};
        flen      = {4'd0, hbytes} + n_length;
        pages     = flen[20:9] + {11'd0, |flen[8:0]};
        base_seg  = r_psp_segment + PARA_BYTES;

        reloc_res                  = '0;
        reloc_res.kind             = KIND_RELOC;
        reloc_res.reloc_segment    = {r_length[19:12], 8'd0};
        reloc_res.reloc_offset_low = r_length[11:0];

        hdr_res                     = '0;
        hdr_res.kind                = n_overflow ? KIND_HEADER_OVFL : KIND_HEADER;
        hdr_res.image_length        = n_length;
        hdr_res.reloc_total         = n_entries;
        hdr_res.header_paragraphs   = {3'd0, hbytes[16:4]};
        hdr_res.page_total          = {4'd0, pages};
        hdr_res.last_page_bytes     = flen[8:0];
        hdr_res.rel_stack_segment   = r_stack_segment - base_seg;
        hdr_res.rel_code_segment    = r_entry_code_segment - base_seg;
        hdr_res.start_stack_pointer = r_stack_pointer + SP_ADJUST;
        hdr_res.start_ip            = r_entry_pointer;

        push0  = reloc_hit ? reloc_res : hdr_res;
        push_n = in_take ? ({1'b0, reloc_hit} + {1'b0, i_item.is_last}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psp_segment        <= '0;
            r_entry_code_segment <= '0;
            r_entry_pointer      <= '0;
            r_stack_segment      <= '0;
            r_stack_pointer      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PSP_SEGMENT:        r_psp_segment        <= i_cfg_data;
                CFG_ENTRY_CODE_SEGMENT: r_entry_code_segment <= i_cfg_data;
                CFG_ENTRY_POINTER:      r_entry_pointer      <= i_cfg_data;
                CFG_STACK_SEGMENT:      r_stack_segment      <= i_cfg_data;
                CFG_STACK_POINTER:      r_stack_pointer      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending     <= 1'b0;
            r_held_first  <= '0;
            r_held_second <= '0;
            r_length      <= '0;
            r_entries     <= '0;
            r_stopped     <= 1'b0;
            r_overflow    <= 1'b0;
        end else if (in_take) begin
            if (i_item.is_last) begin
                r_pending     <= 1'b0;
                r_held_first  <= '0;
                r_held_second <= '0;
                r_length      <= '0;
                r_entries     <= '0;
                r_stopped     <= 1'b0;
                r_overflow    <= 1'b0;
            end else begin
                r_pending     <= n_pending;
                r_held_first  <= n_held_first;
                r_held_second <= n_held_second;
                r_length      <= n_length;
                r_entries     <= n_entries;
                r_stopped     <= n_stopped;
                r_overflow    <= n_overflow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= push0;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + QUEUE_AW'(1)] <= hdr_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QUEUE_AW'(push_n);
            if (out_take) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            r_count <= r_count + QUEUE_CW'(push_n) - QUEUE_CW'(out_take);
        end
    end

endmodule

// ===== hdl/rds_checker.sv =====
// ----------------------------------------------------------------------------
// rds_checker
// Port-level checks for the relocation diff scanner, bound to the top level.
// ----------------------------------------------------------------------------
module rds_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             o_valid,
    input  logic             i_stall,
    input  rds_pkg::t_result o_result
);
    import rds_pkg::*;

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed while stalled");

    a_reloc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind == KIND_RELOC |->
            o_result.reloc_segment[7:0] == 8'd0 && o_result.image_length == '0 &&
            o_result.reloc_total == '0 && o_result.page_total == '0)
        else $error("relocation transaction carries header data");

    a_header_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind != KIND_RELOC |->
            o_result.reloc_segment == '0 && o_result.reloc_offset_low == '0 &&
            o_result.header_paragraphs[4:0] == 5'd0 && o_result.page_total != '0)
        else $error("header transaction malformed");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.kind == KIND_RELOC || o_result.kind == KIND_HEADER ||
            o_result.kind == KIND_HEADER_OVFL)
        else $error("illegal result kind");

endmodule

bind relocation_diff_scanner_core rds_checker u_rds_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);
